// ===== rtl/core/ptach_pkg.sv =====
// Package: shared types, register map and reset values for the pulse group tachometer.
`default_nettype none

package ptach_pkg;

	localparam int STAMP_BITS_DEF = 32;
	localparam int NUM_BITS       = 32;
	localparam int CFG_IDX_BITS   = 8;
	localparam int CFG_DATA_BITS  = 32;

	localparam logic [15:0] RPM_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_EDGE  = 2'd0,
		OP_OVF   = 2'd1,
		OP_QUERY = 2'd2
	} op_t;

	localparam logic [CFG_IDX_BITS-1:0] REG_NUMERATOR = 8'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PPG       = 8'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_TIMEOUT   = 8'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MS_OVF    = 8'd3;

	localparam logic [31:0] NUMERATOR_RST = 32'd960000000;
	localparam logic [4:0]  PPG_RST       = 5'd20;
	localparam logic [15:0] TIMEOUT_RST   = 16'd200;
	localparam logic [7:0]  MS_OVF_RST    = 8'd4;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] capture_count;
		logic        motor_running;
	} item_t;

	typedef struct packed {
		logic [15:0] rpm;
		logic        rpm_fresh;
		logic        stalled;
	} result_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIVIDE
	} state_t;

	typedef struct packed {
		logic start;
	} div_ctrl_t;

	typedef struct packed {
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/pulse_group_tachometer_top.sv =====
// Top level: tachometer state, register file, sequencer and result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------
//  item     | item_valid / item_ready  | item   (opcode, count, running)
//  result   | result_valid/result_ready| result (rpm, fresh, stalled)
//  cfg      | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Edge, overflow, unused opcodes and queries that compute nothing new: result in the next cycle.
// An unstalled query with a fresh period runs the divider: 32 steps.
// item_ready drops during a divide and while an undelivered result is not taken.
// cfg_ready is always high. Reset loads all state but the result payload and the divider datapath; no clearing pass.
`default_nettype none

module pulse_group_tachometer_top #(
	parameter int STAMP_BITS = ptach_pkg::STAMP_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  item_valid,
	output logic                                 item_ready,
	input  ptach_pkg::item_t                     item,
	output logic                                 result_valid,
	input  wire                                  result_ready,
	output ptach_pkg::result_t                   result,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [ptach_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire [ptach_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import ptach_pkg::*;

	// configuration
	logic [31:0] numerator_q;
	logic [4:0]  ppg_q;
	logic [15:0] timeout_q;
	logic [7:0]  ms_ovf_q;

	// tachometer state
	logic [STAMP_BITS-1:0] ovf_base_q;
	logic [STAMP_BITS-1:0] first_stamp_q;
	logic [STAMP_BITS-1:0] period_q;
	logic [31:0]           ms_count_q;
	logic [31:0]           last_edge_ms_q;
	logic [4:0]            edge_idx_q;
	logic                  period_ready_q;
	logic [15:0]           rpm_held_q;

	state_t    state_q, state_d;
	result_t   result_q;
	logic      result_valid_q;

	div_ctrl_t             div_ctrl;
	div_stat_t             div_stat;
	logic [NUM_BITS-1:0]   quotient;

	logic                  accept;
	logic                  is_query;
	logic                  stall;
	logic                  go_div;
	logic [STAMP_BITS-1:0] now;
	logic [4:0]            idx_inc;
	logic [15:0]           rpm_sat;

	assign accept   = item_valid && item_ready;
	assign is_query = item.opcode == OP_QUERY;
	assign stall    = !item.motor_running ||
	                  ((ms_count_q - last_edge_ms_q) > 32'(timeout_q));
	assign go_div   = accept && is_query && !stall && period_ready_q;
	assign now      = ovf_base_q + STAMP_BITS'(item.capture_count);
	assign idx_inc  = edge_idx_q + 5'd1;
	assign rpm_sat  = (quotient[NUM_BITS-1:16] != '0) ? RPM_MAX : quotient[15:0];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			numerator_q <= NUMERATOR_RST;
			ppg_q       <= PPG_RST;
			timeout_q   <= TIMEOUT_RST;
			ms_ovf_q    <= MS_OVF_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_NUMERATOR: numerator_q <= cfg_data;
				REG_PPG:       ppg_q       <= cfg_data[4:0];
				REG_TIMEOUT:   timeout_q   <= cfg_data[15:0];
				REG_MS_OVF:    ms_ovf_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_base_q     <= '0;
			first_stamp_q  <= '0;
			period_q       <= '0;
			ms_count_q     <= '0;
			last_edge_ms_q <= '0;
			edge_idx_q     <= '0;
			period_ready_q <= 1'b0;
			rpm_held_q     <= '0;
		end else begin
			if (accept) begin
				unique case (item.opcode)
					OP_EDGE: begin
						last_edge_ms_q <= ms_count_q;
						edge_idx_q     <= idx_inc;
						if (idx_inc == 5'd1) begin
							first_stamp_q <= now;
						end else if (idx_inc >= ppg_q) begin
							// group size below two acts as two
							period_q       <= now - first_stamp_q;
							edge_idx_q     <= '0;
							first_stamp_q  <= now;
							period_ready_q <= 1'b1;
						end
					end
					OP_OVF: begin
						ovf_base_q <= ovf_base_q + STAMP_BITS'(17'h10000);
						ms_count_q <= ms_count_q + 32'(ms_ovf_q);
					end
					OP_QUERY: begin
						if (stall)
							rpm_held_q <= '0;
						else if (period_ready_q)
							period_ready_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (div_stat.done)
				rpm_held_q <= rpm_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (go_div) state_d = ST_DIVIDE;
			ST_DIVIDE: if (div_stat.done) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		item_ready     = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
		div_ctrl.start = go_div;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready)
				result_valid_q <= 1'b0;
			if ((accept && !go_div) || div_stat.done)
				result_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_stat.done) begin
			result_q.rpm       <= rpm_sat;
			result_q.rpm_fresh <= 1'b1;
			result_q.stalled   <= 1'b0;
		end else if (accept && !go_div) begin
			result_q.rpm       <= (is_query && stall) ? 16'd0 : rpm_held_q;
			result_q.rpm_fresh <= 1'b0;
			result_q.stalled   <= is_query && stall;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	ptach_div #(
		.DIV_BITS(STAMP_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (div_ctrl),
		.numerator (numerator_q),
		.divisor   (period_q),
		.stat      (div_stat),
		.quotient  (quotient)
	);

endmodule

`default_nettype wire

// ===== rtl/core/ptach_div.sv =====
// Iterative restoring divider: one quotient bit per cycle.
`default_nettype none

module ptach_div #(
	parameter int DIV_BITS = ptach_pkg::STAMP_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  ptach_pkg::div_ctrl_t             ctrl,
	input  wire [ptach_pkg::NUM_BITS-1:0]    numerator,
	input  wire [DIV_BITS-1:0]               divisor,
	output ptach_pkg::div_stat_t             stat,
	output logic [ptach_pkg::NUM_BITS-1:0]   quotient
);
	import ptach_pkg::*;

	localparam int RW      = ((DIV_BITS > NUM_BITS) ? DIV_BITS : NUM_BITS) + 1;
	localparam int CNT_W   = $clog2(NUM_BITS + 1);

	logic [RW-1:0]       rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DIV_BITS-1:0] divisor_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] div_ext;
	logic          fits;

	// divisor of zero always fits, so the quotient comes out all ones
	assign rem_sh  = {rem_q[RW-2:0], quo_q[NUM_BITS-1]};
	assign div_ext = RW'(divisor_q);
	assign fits    = rem_sh >= div_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(1));
			if (ctrl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			rem_q     <= '0;
			quo_q     <= numerator;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? (rem_sh - div_ext) : rem_sh;
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/core/ptach_checker.sv =====
// Port-level checker for the tachometer top, bound in below.
`default_nettype none

module ptach_checker (
	input wire                                  clk,
	input wire                                  arst_n,
	input wire                                  item_valid,
	input wire                                  item_ready,
	input wire                                  result_valid,
	input wire                                  result_ready,
	input ptach_pkg::result_t                   result
);
	import ptach_pkg::*;

	// a held result stays put until taken
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// a stalled query reports zero and no fresh value
	a_stall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.stalled |-> result.rpm == 16'd0 && !result.rpm_fresh)
		else $error("stalled result with nonzero rpm or fresh flag");

	// a request either yields a result next cycle or holds off the next one
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid || !item_ready)
		else $error("request accepted with no result and no busy");

	// no new request while an older result is stuck downstream
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("request taken over a pending result");

endmodule

bind pulse_group_tachometer_top ptach_checker u_ptach_checker (.*);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench: pulse group tachometer checked against a cycle-free predictor of its state.
`timescale 1ns / 100ps

module testbench;
	import ptach_pkg::*;

	localparam logic [1:0]  OP_SPARE    = 2'd3;
	localparam logic [7:0]  REG_NONE    = 8'hFF;
	localparam int          DRAIN_TAIL  = 40;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 292;
	localparam int          DIR_ROWS    = 34;

	typedef struct {
		logic        is_reg;
		logic [7:0]  reg_idx;
		logic [31:0] reg_val;
		item_t       req;
		logic        typed;
		result_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	item_t       req_item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	result_t     tach_result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of the register file
	logic [31:0] cfg_numer   = NUMERATOR_RST;
	logic [4:0]  cfg_ppg     = PPG_RST;
	logic [15:0] cfg_timeout = TIMEOUT_RST;
	logic [7:0]  cfg_ms_ovf  = MS_OVF_RST;

	// predictor copy of the tachometer state
	logic [STAMP_BITS_DEF-1:0] time_base      = '0;
	logic [STAMP_BITS_DEF-1:0] grp_start      = '0;
	logic [STAMP_BITS_DEF-1:0] grp_period     = '0;
	logic [31:0]               ms_now         = '0;
	logic [31:0]               edge_ms        = '0;
	logic [4:0]                edge_cnt       = '0;
	logic                      period_pending = 1'b0;
	logic [15:0]               rpm_hold       = '0;

	result_t rpm_expect_q[$];
	result_t rpm_want;
	int      fail_count = 0;
	int      cycle_count = 0;
	int      src_idle_pct = 0;
	int      sink_stall_pct = 0;

	plan_row_t dir_plan [DIR_ROWS] = '{
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0}},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b1}},
		'{1'b0, 8'd0, 32'd0, '{OP_SPARE, 16'hFFFF, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0}},
		'{1'b0, 8'd0, 32'd0, '{OP_OVF,   16'h0000, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h0000, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b0}},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'hFFFF, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b0}},
		'{1'b1, REG_PPG, 32'd2, '0, 1'b0, '0},
		'{1'b1, REG_NUMERATOR, 32'hFFFF_FFFF, '0, 1'b0, '0},
		// this edge closes the group: the edge count already reaches the new group size
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h0010, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b0, '0},
		// same stamp twice: zero period
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h0100, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h0100, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b1, '{RPM_MAX, 1'b1, 1'b0}},
		'{1'b1, REG_TIMEOUT, 32'd0, '0, 1'b0, '0},
		'{1'b1, REG_MS_OVF, 32'd255, '0, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_OVF,   16'h0000, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b1, '{16'd0, 1'b0, 1'b1}},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h8000, 1'b1}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b0, '0},
		// group size zero behaves as two
		'{1'b1, REG_PPG, 32'd0, '0, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h8123, 1'b0}, 1'b0, '0},
		'{1'b1, REG_NUMERATOR, 32'd1, '0, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b0, '0},
		'{1'b1, REG_NONE, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{1'b1, REG_PPG, 32'd1, '0, 1'b0, '0},
		'{1'b1, REG_TIMEOUT, 32'd65535, '0, 1'b0, '0},
		'{1'b1, REG_MS_OVF, 32'd0, '0, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'h0000, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_OVF,   16'hFFFF, 1'b0}, 1'b0, '0},
		'{1'b0, 8'd0, 32'd0, '{OP_EDGE,  16'hFFFF, 1'b0}, 1'b0, '0},
		// stall must keep the waiting period for the next query
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b0}, 1'b1, '{16'd0, 1'b0, 1'b1}},
		'{1'b0, 8'd0, 32'd0, '{OP_QUERY, 16'h0000, 1'b1}, 1'b0, '0},
		'{1'b1, REG_NUMERATOR, NUMERATOR_RST, '0, 1'b0, '0}
	};

	pulse_group_tachometer_top u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (req_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (tach_result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the predicted tachometer by one request, return the expected result
	function automatic result_t tach_predict(item_t it);
		result_t                   r;
		logic [STAMP_BITS_DEF-1:0] stamp;
		logic [31:0]               quot;
		r = '0;
		case (it.opcode)
			OP_EDGE: begin
				stamp = time_base + STAMP_BITS_DEF'(it.capture_count);
				edge_ms = ms_now;
				edge_cnt = edge_cnt + 5'd1;
				if (edge_cnt == 5'd1) begin
					grp_start = stamp;
				end else if (edge_cnt >= cfg_ppg) begin
					grp_period = stamp - grp_start;
					grp_start = stamp;
					edge_cnt = '0;
					period_pending = 1'b1;
				end
			end
			OP_OVF: begin
				time_base = time_base + STAMP_BITS_DEF'(32'h1_0000);
				ms_now = ms_now + 32'(cfg_ms_ovf);
			end
			OP_QUERY: begin
				if (!it.motor_running || (ms_now - edge_ms) > 32'(cfg_timeout)) begin
					rpm_hold = '0;
					r.stalled = 1'b1;
				end else if (period_pending) begin
					period_pending = 1'b0;
					r.rpm_fresh = 1'b1;
					if (grp_period == '0) begin
						rpm_hold = RPM_MAX;
					end else begin
						quot = cfg_numer / grp_period;
						rpm_hold = (quot > 32'(RPM_MAX)) ? RPM_MAX : quot[15:0];
					end
				end
			end
			default: ;
		endcase
		r.rpm = rpm_hold;
		return r;
	endfunction

	task automatic push_item(input item_t it, input logic typed = 1'b0,
			input result_t typed_want = '0);
		int      gap;
		result_t predicted;
		gap = 0;
		while (gap < 200 && $urandom_range(99) < src_idle_pct)
			gap++;
		@(negedge clk);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
		predicted = tach_predict(it);
		rpm_expect_q.push_back(typed ? typed_want : predicted);
	endtask

	// stop requesting until every result is back and a divide could have finished
	task automatic wait_drained();
		@(negedge clk);
		item_valid <= 1'b0;
		while (rpm_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_NUMERATOR: cfg_numer = val;
			REG_PPG:       cfg_ppg = val[4:0];
			REG_TIMEOUT:   cfg_timeout = val[15:0];
			REG_MS_OVF:    cfg_ms_ovf = val[7:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		result_ready <= ($urandom_range(99) >= sink_stall_pct);

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (rpm_expect_q.size() == 0) begin
				fail_count++;
				$display("%0t: result with no request pending: rpm=%0d fresh=%0b stalled=%0b",
					$time, tach_result.rpm, tach_result.rpm_fresh, tach_result.stalled);
			end else begin
				rpm_want = rpm_expect_q.pop_front();
				if (tach_result.rpm !== rpm_want.rpm ||
						tach_result.rpm_fresh !== rpm_want.rpm_fresh ||
						tach_result.stalled !== rpm_want.stalled) begin
					fail_count++;
					$display("%0t: mismatch: expected rpm=%0d fresh=%0b stalled=%0b, got rpm=%0d fresh=%0b stalled=%0b",
						$time, rpm_want.rpm, rpm_want.rpm_fresh, rpm_want.stalled,
						tach_result.rpm, tach_result.rpm_fresh, tach_result.stalled);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, rpm_expect_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		item_t       rnd_item;
		logic [15:0] count_track;
		logic        carry;
		int          pick;
		count_track = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		foreach (dir_plan[i]) begin
			if (dir_plan[i].is_reg) begin
				wait_drained();
				write_reg(dir_plan[i].reg_idx, dir_plan[i].reg_val);
			end else begin
				push_item(dir_plan[i].req, dir_plan[i].typed, dir_plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: begin
					write_reg(REG_NUMERATOR, NUMERATOR_RST);
					write_reg(REG_PPG, 32'(PPG_RST));
					write_reg(REG_TIMEOUT, 32'(TIMEOUT_RST));
					write_reg(REG_MS_OVF, 32'(MS_OVF_RST));
				end
				1: begin
					write_reg(REG_NUMERATOR, 32'hFFFF_FFFF);
					write_reg(REG_PPG, 32'd2);
					write_reg(REG_TIMEOUT, 32'd0);
					write_reg(REG_MS_OVF, 32'd255);
				end
				2: begin
					write_reg(REG_NUMERATOR, 32'd1);
					write_reg(REG_PPG, 32'd31);
					write_reg(REG_TIMEOUT, 32'd65535);
					write_reg(REG_MS_OVF, 32'd0);
				end
				5: begin
					write_reg(REG_NUMERATOR, 32'($urandom_range(20000000)));
					write_reg(REG_PPG, 32'd3);
					write_reg(REG_TIMEOUT, 32'($urandom_range(400)));
					write_reg(REG_MS_OVF, 32'($urandom_range(1, 8)));
				end
				default: begin
					// narrow registers get junk in the unused upper bits
					write_reg(REG_NUMERATOR, $urandom);
					write_reg(REG_PPG, ($urandom & ~32'h1F) | 32'($urandom_range(31)));
					write_reg(REG_TIMEOUT, $urandom);
					write_reg(REG_MS_OVF, $urandom);
					write_reg(8'($urandom_range(REG_MS_OVF + 1, REG_NONE)), $urandom);
				end
			endcase
			case (ph % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 88; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 88; end
				default: begin src_idle_pct = 34; sink_stall_pct = 34; end
			endcase

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(99);
				rnd_item = '0;
				rnd_item.capture_count = 16'($urandom_range(16'hFFFF));
				rnd_item.motor_running = ($urandom_range(99) < 88);
				if (pick < 48) begin
					rnd_item.opcode = OP_EDGE;
					// mostly a running timer; a wrap turns the request into the overflow
					if ($urandom_range(3) != 0) begin
						{carry, count_track} = {1'b0, count_track} + 17'($urandom_range(1, 6000));
						rnd_item.capture_count = count_track;
						if (carry)
							rnd_item.opcode = OP_OVF;
					end
				end else if (pick < 64) begin
					rnd_item.opcode = OP_OVF;
				end else if (pick < 95) begin
					rnd_item.opcode = OP_QUERY;
				end else begin
					rnd_item.opcode = OP_SPARE;
				end
				push_item(rnd_item);
				if ($urandom_range(199) == 0)
					wait_drained();
			end
		end

		wait_drained();
		if (fail_count == 0 && rpm_expect_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
